// File: rtl/clmm_pkg.sv
// Shared types, constants and the sine table for the cone landmark map merge block.
`timescale 1ns / 1ps
`default_nettype none

package clmm_pkg;

    localparam int TABLE_DEPTH     = 64;
    localparam int TRIG_TABLE_BITS = 10;
    localparam int NUM_COLORS      = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W  = IDX_W + 2;
    localparam int MEM_DEPTH = 4 * TABLE_DEPTH;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int Q_BITS  = TRIG_TABLE_BITS - 2;
    localparam int SIN_N   = (1 << Q_BITS) + 1;
    localparam int SIN_AW  = Q_BITS + 1;

    localparam int DIV_W       = 36;
    localparam int RECIP_SHIFT = 35;
    localparam logic [30:0] RECIP_25   = 31'd1374389535;
    localparam logic [35:0] ROUND_HALF = 36'd50;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    localparam logic [9:0]  GATE_ROW_RESET    = 10'd300;
    localparam logic [7:0]  CAM_OFFSET_RESET  = 8'd22;
    localparam logic [31:0] CONE_RAD_RESET    = 32'd262144;
    localparam logic [31:0] YELLOW_RAD_RESET  = 32'd131072;

    localparam logic [7:0] CFG_GATE_ROW   = 8'd0;
    localparam logic [7:0] CFG_CAM_OFFSET = 8'd1;
    localparam logic [7:0] CFG_CONE_RAD   = 8'd2;
    localparam logic [7:0] CFG_YELLOW_RAD = 8'd3;

    localparam logic [1:0] COLOR_YELLOW = 2'd2;
    localparam logic [1:0] COLOR_OTHER  = 2'd3;

    typedef enum logic [2:0] {
        OUT_IGNORED   = 3'd0,
        OUT_MERGED    = 3'd1,
        OUT_APPENDED  = 3'd2,
        OUT_FULL      = 3'd3,
        OUT_FRAME_END = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        KIND_IGNORE    = 2'd0,
        KIND_DETECT    = 2'd1,
        KIND_FRAME_END = 2'd2
    } item_kind_t;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL1, F_MUL2, F_MUL3, F_PREP, F_DIV, F_FIN, F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE, B_SCAN, B_HIT, B_APPEND
    } back_state_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [1:0]         color;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
    } clmm_item_t;

    typedef struct packed {
        logic [31:0] cone_rad;
        logic [31:0] yellow_rad;
    } radius_cfg_t;

    typedef logic [16:0] sin_tab_t [SIN_N];

    // Sine of r/16384 quarter turns in Q1.16 by an odd series in Q2.30.
    function automatic logic [16:0] sin_quarter(input logic [14:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic signed [63:0] s;
        x  = ({49'd0, r} * PI_HALF_Q30) >> 14;
        x2 = (x * x) >> 30;
        t  = x;
        s  = $signed(x);
        t  = ((t * x2) >> 30) / 64'd6;   s = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd20;  s = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd42;  s = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd72;  s = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd110; s = s - $signed(t);
        if (s < 0)
        begin
            s = 64'sd0;
        end
        s = (s + 64'sd8192) >>> 14;
        if (s > 64'sd65536)
        begin
            s = 64'sd65536;
        end
        return s[16:0];
    endfunction

    function automatic sin_tab_t gen_sin_tab();
        sin_tab_t tab;
        for (int k = 0; k < SIN_N; k++)
        begin
            tab[k] = sin_quarter(15'(k << (16 - TRIG_TABLE_BITS)));
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = gen_sin_tab();

endpackage

`default_nettype wire

// File: rtl/clmm_front.sv
// Front part: configuration registers, item intake, classification and world transform.
`timescale 1ns / 1ps
`default_nettype none

module clmm_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [127:0]         s_axis_tdata,
    input  wire logic                 s_axis_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [7:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    output clmm_pkg::radius_cfg_t     radius_cfg,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output clmm_pkg::clmm_item_t      push_item
);
    import clmm_pkg::*;

    front_state_t state_reg, state_next;

    logic [9:0]  gate_row_reg;
    logic [7:0]  cam_offset_reg;
    logic [31:0] cone_rad_reg;
    logic [31:0] yellow_rad_reg;

    clmm_item_t item_reg, item_next;
    logic signed [16:0] f_reg, f_next;
    logic signed [16:0] lat_reg, lat_next;
    logic signed [17:0] cos_reg, cos_next;
    logic signed [17:0] sin_reg, sin_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic signed [34:0] prod_a_reg, prod_a_next;
    logic signed [34:0] prod_b_reg, prod_b_next;
    logic signed [35:0] sumx_reg, sumx_next;
    logic signed [35:0] sumy_reg, sumy_next;
    logic [DIV_W-1:0] magx_reg, magx_next;
    logic [DIV_W-1:0] magy_reg, magy_next;
    logic negx_reg, negx_next;
    logic negy_reg, negy_next;

    logic [1:0]  in_color;
    logic [9:0]  in_bottom;
    logic signed [15:0] in_lat;
    logic signed [15:0] in_fwd;
    logic signed [31:0] in_px;
    logic [15:0] in_head;
    logic [Q_BITS-1:0] tab_k;
    logic [16:0] sr;
    logic [16:0] cr;
    logic [61:0] quot_x_prod;
    logic [61:0] quot_y_prod;

    function automatic logic signed [31:0] place(input logic signed [31:0] p,
                                                 input logic [DIV_W-1:0] q,
                                                 input logic neg);
        logic signed [37:0] qs;
        logic signed [37:0] tot;
        qs  = $signed({2'b00, q});
        tot = {{6{p[31]}}, p} + (neg ? -qs : qs);
        if (tot[37:31] != {7{tot[37]}})
        begin
            return tot[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return tot[31:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign radius_cfg.cone_rad   = cone_rad_reg;
    assign radius_cfg.yellow_rad = yellow_rad_reg;

    assign in_color  = s_axis_tdata[1:0];
    assign in_bottom = s_axis_tdata[11:2];
    assign in_lat    = s_axis_tdata[27:12];
    assign in_fwd    = s_axis_tdata[43:28];
    assign in_px     = s_axis_tdata[75:44];
    assign in_head   = s_axis_tdata[123:108];
    assign tab_k     = in_head[13 -: Q_BITS];
    assign sr        = SIN_TAB[{1'b0, tab_k}];
    assign cr        = SIN_TAB[SIN_AW'(1 << Q_BITS) - {1'b0, tab_k}];

    // The rounded magnitude stays below 2^33, so a quarter of it fits 31 bits and
    // one reciprocal multiply by 1/25 gives the exact quotient by 100.
    assign quot_x_prod = magx_reg[32:2] * RECIP_25;
    assign quot_y_prod = magy_reg[32:2] * RECIP_25;

    assign push_item  = item_reg;
    assign push_valid = (state_reg == F_PUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_row_reg   <= GATE_ROW_RESET;
            cam_offset_reg <= CAM_OFFSET_RESET;
            cone_rad_reg   <= CONE_RAD_RESET;
            yellow_rad_reg <= YELLOW_RAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GATE_ROW:   gate_row_reg   <= cfg_data[9:0];
                CFG_CAM_OFFSET: cam_offset_reg <= cfg_data[7:0];
                CFG_CONE_RAD:   cone_rad_reg   <= cfg_data;
                CFG_YELLOW_RAD: yellow_rad_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        f_reg       <= f_next;
        lat_reg     <= lat_next;
        cos_reg     <= cos_next;
        sin_reg     <= sin_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        prod_a_reg  <= prod_a_next;
        prod_b_reg  <= prod_b_next;
        sumx_reg    <= sumx_next;
        sumy_reg    <= sumy_next;
        magx_reg    <= magx_next;
        magy_reg    <= magy_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        f_next        = f_reg;
        lat_next      = lat_reg;
        cos_next      = cos_reg;
        sin_next      = sin_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        prod_a_next   = prod_a_reg;
        prod_b_next   = prod_b_reg;
        sumx_next     = sumx_reg;
        sumy_next     = sumy_reg;
        magx_next     = magx_reg;
        magy_next     = magy_reg;
        negx_next     = negx_reg;
        negy_next     = negy_reg;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    item_next.color = in_color;
                    item_next.gx    = 32'sd0;
                    item_next.gy    = 32'sd0;
                    f_next   = $signed({in_fwd[15], in_fwd}) - $signed({9'd0, cam_offset_reg});
                    lat_next = $signed({in_lat[15], in_lat});
                    px_next  = in_px;
                    py_next  = s_axis_tdata[107:76];
                    unique case (in_head[15:14])
                        2'd0:
                        begin
                            sin_next = $signed({1'b0, sr});
                            cos_next = $signed({1'b0, cr});
                        end
                        2'd1:
                        begin
                            sin_next = $signed({1'b0, cr});
                            cos_next = -$signed({1'b0, sr});
                        end
                        2'd2:
                        begin
                            sin_next = -$signed({1'b0, sr});
                            cos_next = -$signed({1'b0, cr});
                        end
                        default:
                        begin
                            sin_next = -$signed({1'b0, cr});
                            cos_next = $signed({1'b0, sr});
                        end
                    endcase
                    if (s_axis_tuser)
                    begin
                        item_next.kind = KIND_FRAME_END;
                        state_next     = F_PUSH;
                    end
                    else if (in_color == COLOR_OTHER || in_bottom < gate_row_reg
                             || in_px <= 32'sd0)
                    begin
                        item_next.kind = KIND_IGNORE;
                        state_next     = F_PUSH;
                    end
                    else
                    begin
                        item_next.kind = KIND_DETECT;
                        state_next     = F_MUL1;
                    end
                end
            end
            F_MUL1:
            begin
                prod_a_next = f_reg * cos_reg;
                prod_b_next = lat_reg * sin_reg;
                state_next  = F_MUL2;
            end
            F_MUL2:
            begin
                sumx_next   = $signed({prod_a_reg[34], prod_a_reg})
                            + $signed({prod_b_reg[34], prod_b_reg});
                prod_a_next = f_reg * sin_reg;
                prod_b_next = lat_reg * cos_reg;
                state_next  = F_MUL3;
            end
            F_MUL3:
            begin
                sumy_next  = $signed({prod_a_reg[34], prod_a_reg})
                           - $signed({prod_b_reg[34], prod_b_reg});
                state_next = F_PREP;
            end
            F_PREP:
            begin
                negx_next    = sumx_reg[35];
                negy_next    = sumy_reg[35];
                magx_next    = (sumx_reg[35] ? 36'(-sumx_reg) : 36'(sumx_reg)) + ROUND_HALF;
                magy_next    = (sumy_reg[35] ? 36'(-sumy_reg) : 36'(sumy_reg)) + ROUND_HALF;
                state_next   = F_DIV;
            end
            F_DIV:
            begin
                magx_next  = DIV_W'(quot_x_prod[61:RECIP_SHIFT]);
                magy_next  = DIV_W'(quot_y_prod[61:RECIP_SHIFT]);
                state_next = F_FIN;
            end
            F_FIN:
            begin
                item_next.gx = place(px_reg, magx_reg, negx_reg);
                item_next.gy = place(py_reg, magy_reg, negy_reg);
                state_next   = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/clmm_queue.sv
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module clmm_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire clmm_pkg::clmm_item_t push_item,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output clmm_pkg::clmm_item_t      pop_item
);
    import clmm_pkg::*;

    clmm_item_t slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/clmm_back.sv
// Back part: per-colour landmark tables, radius scan, merge or append, result register.
`timescale 1ns / 1ps
`default_nettype none

module clmm_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire clmm_pkg::radius_cfg_t radius_cfg,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire clmm_pkg::clmm_item_t pop_item,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [79:0]               m_axis_tdata,
    output logic [2:0]                m_axis_tuser
);
    import clmm_pkg::*;

    logic [63:0] mem [MEM_DEPTH];
    logic [63:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [63:0]       wr_data;

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg [NUM_COLORS];
    logic [CNT_W-1:0] count_next [NUM_COLORS];
    logic [NUM_COLORS-1:0] seeded_reg, seeded_next;
    logic [NUM_COLORS-1:0] stored_reg, stored_next;

    logic [1:0]         color_reg, color_next;
    logic signed [31:0] gx_reg, gx_next;
    logic signed [31:0] gy_reg, gy_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [31:0]        rad_reg, rad_next;

    logic             p1_v_reg, p1_v_next;
    logic [IDX_W-1:0] p1_idx_reg;
    logic             p2_v_reg, p2_v_next;
    logic             p2_in_reg;
    logic [47:0]      p2_sqx_reg;
    logic [47:0]      p2_sqy_reg;
    logic [IDX_W-1:0] p2_idx_reg;
    logic [31:0]      p2_ex_reg;
    logic [31:0]      p2_ey_reg;

    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]      hit_ex_reg, hit_ex_next;
    logic [31:0]      hit_ey_reg, hit_ey_next;

    logic             out_valid_reg, out_valid_next;
    outcome_t         out_outcome_reg, out_outcome_next;
    logic [5:0]       out_idx_reg, out_idx_next;
    logic [31:0]      out_x_reg, out_x_next;
    logic [31:0]      out_y_reg, out_y_next;
    logic [6:0]       out_cnt_reg, out_cnt_next;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               hit;
    logic [31:0]        avg_x;
    logic [31:0]        avg_y;

    function automatic logic [31:0] avg2(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] sum;
        sum = $signed({a[31], a}) + $signed({b[31], b});
        return sum[32:1];
    endfunction

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_outcome_reg;
    assign m_axis_tdata  = {3'd0, out_cnt_reg, out_y_reg, out_x_reg, out_idx_reg};

    assign dx = $signed({rd_data_reg[31], rd_data_reg[31:0]}) - $signed({gx_reg[31], gx_reg});
    assign dy = $signed({rd_data_reg[63], rd_data_reg[63:32]}) - $signed({gy_reg[31], gy_reg});
    assign ax = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay = dy[32] ? 33'(-dy) : 33'(dy);
    assign hit = p2_v_reg && p2_in_reg
              && (({1'b0, p2_sqx_reg} + {1'b0, p2_sqy_reg}) < {1'b0, rad_reg, 16'd0});
    assign avg_x = avg2(hit_ex_reg, gx_reg);
    assign avg_y = avg2(hit_ey_reg, gy_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg  <= issue_reg[IDX_W-1:0];
        p2_in_reg   <= (ax[32:24] == '0) && (ay[32:24] == '0);
        p2_sqx_reg  <= ax[23:0] * ax[23:0];
        p2_sqy_reg  <= ay[23:0] * ay[23:0];
        p2_idx_reg  <= p1_idx_reg;
        p2_ex_reg   <= rd_data_reg[31:0];
        p2_ey_reg   <= rd_data_reg[63:32];
        color_reg   <= color_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        n_reg       <= n_next;
        issue_reg   <= issue_next;
        rad_reg     <= rad_next;
        hit_idx_reg <= hit_idx_next;
        hit_ex_reg  <= hit_ex_next;
        hit_ey_reg  <= hit_ey_next;
        out_outcome_reg <= out_outcome_next;
        out_idx_reg <= out_idx_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_cnt_reg <= out_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            seeded_reg    <= '0;
            stored_reg    <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            stored_reg    <= stored_next;
            p1_v_reg      <= p1_v_next;
            p2_v_reg      <= p2_v_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                count_reg[c] <= count_next[c];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        seeded_next  = seeded_reg;
        stored_next  = stored_reg;
        color_next   = color_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        n_next       = n_reg;
        issue_next   = issue_reg;
        rad_next     = rad_reg;
        hit_idx_next = hit_idx_reg;
        hit_ex_next  = hit_ex_reg;
        hit_ey_next  = hit_ey_reg;
        p1_v_next    = 1'b0;
        p2_v_next    = p1_v_reg;
        rd_en        = 1'b0;
        rd_addr      = {color_reg, issue_reg[IDX_W-1:0]};
        wr_en        = 1'b0;
        wr_addr      = {color_reg, hit_idx_reg};
        wr_data      = {avg_y, avg_x};
        pop_ready    = 1'b0;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_outcome_next = out_outcome_reg;
        out_idx_next     = out_idx_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_cnt_next     = out_cnt_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid && !out_valid_reg)
                begin
                    pop_ready    = 1'b1;
                    color_next   = pop_item.color;
                    gx_next      = pop_item.gx;
                    gy_next      = pop_item.gy;
                    issue_next   = '0;
                    rad_next     = (pop_item.color == COLOR_YELLOW) ? radius_cfg.yellow_rad
                                                                    : radius_cfg.cone_rad;
                    out_idx_next = 6'd0;
                    out_x_next   = 32'd0;
                    out_y_next   = 32'd0;
                    out_cnt_next = 7'd0;
                    unique case (pop_item.kind)
                        KIND_FRAME_END:
                        begin
                            seeded_next      = seeded_reg | stored_reg;
                            stored_next      = '0;
                            out_outcome_next = OUT_FRAME_END;
                            out_valid_next   = 1'b1;
                        end
                        KIND_DETECT:
                        begin
                            n_next = count_reg[pop_item.color];
                            if (seeded_reg[pop_item.color]
                                && count_reg[pop_item.color] != '0)
                            begin
                                state_next = B_SCAN;
                            end
                            else
                            begin
                                state_next = B_APPEND;
                            end
                        end
                        default:
                        begin
                            out_outcome_next = OUT_IGNORED;
                            out_valid_next   = 1'b1;
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                if (hit)
                begin
                    hit_idx_next = p2_idx_reg;
                    hit_ex_next  = p2_ex_reg;
                    hit_ey_next  = p2_ey_reg;
                    p2_v_next    = 1'b0;
                    state_next   = B_HIT;
                end
                else if (issue_reg < n_reg)
                begin
                    rd_en      = 1'b1;
                    p1_v_next  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                else if (!p1_v_reg && !p2_v_reg)
                begin
                    state_next = B_APPEND;
                end
            end
            B_HIT:
            begin
                out_outcome_next = OUT_MERGED;
                out_idx_next     = 6'(hit_idx_reg);
                out_cnt_next     = 7'(n_reg);
                out_valid_next   = 1'b1;
                if (color_reg == COLOR_YELLOW)
                begin
                    out_x_next = hit_ex_reg;
                    out_y_next = hit_ey_reg;
                end
                else
                begin
                    wr_en      = 1'b1;
                    out_x_next = avg_x;
                    out_y_next = avg_y;
                end
                state_next = B_IDLE;
            end
            B_APPEND:
            begin
                out_x_next     = gx_reg;
                out_y_next     = gy_reg;
                out_valid_next = 1'b1;
                if (n_reg < CNT_W'(TABLE_DEPTH))
                begin
                    wr_en                  = 1'b1;
                    wr_addr                = {color_reg, n_reg[IDX_W-1:0]};
                    wr_data                = {gy_reg, gx_reg};
                    count_next[color_reg]  = n_reg + 1'b1;
                    if (!seeded_reg[color_reg])
                    begin
                        stored_next[color_reg] = 1'b1;
                    end
                    out_outcome_next = OUT_APPENDED;
                    out_idx_next     = 6'(n_reg[IDX_W-1:0]);
                    out_cnt_next     = 7'(n_reg + 1'b1);
                end
                else
                begin
                    out_outcome_next = OUT_FULL;
                    out_idx_next     = 6'd0;
                    out_cnt_next     = 7'(n_reg);
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/cone_landmark_map_merge_core.sv
// Top level of the cone landmark map merge block.
// A detection passes in the front through intake, three multiply steps, rounding, one
// reciprocal multiply for the divide by 100, the saturating add and the queue transfer,
// then through the pipelined table scan in the back, which uses one memory read port;
// ignored and frame-end items go from intake straight to the queue transfer.
// Front and back overlap through a two-entry queue; one result is emitted per item.
// Reset clears counts, seeded and stored flags and all handshakes; table contents are
// left unset, as only entries below the count are ever read. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module cone_landmark_map_merge_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // cone_color, box_bottom, lateral_cm, forward_cm, pose_x, pose_y, heading, zero pad
    input  wire logic [127:0] s_axis_tdata,
    // action
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // entry_index, entry_x, entry_y, table_count, zero pad
    output logic [79:0]       m_axis_tdata,
    // outcome
    output logic [2:0]        m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import clmm_pkg::*;

    radius_cfg_t radius_cfg;
    clmm_item_t  push_item;
    clmm_item_t  pop_item;
    logic        push_valid;
    logic        push_ready;
    logic        pop_valid;
    logic        pop_ready;

    clmm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .radius_cfg    (radius_cfg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    clmm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    clmm_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .radius_cfg    (radius_cfg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/clmm_checker.sv
// Port-level checker for the cone landmark map merge block, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module clmm_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [127:0] s_axis_tdata,
    input wire logic         s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [79:0]  m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [7:0]   cfg_index,
    input wire logic [31:0]  cfg_data
);
    import clmm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result withdrawn before its transfer.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result changed while stalled.");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == OUT_IGNORED || m_axis_tuser == OUT_FRAME_END)
        |-> m_axis_tdata == '0)
        else $error("Ignored or frame-end result carries data.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == OUT_FULL
        |-> m_axis_tdata[5:0] == 6'd0 && m_axis_tdata[76:70] == 7'(TABLE_DEPTH))
        else $error("Table-full result with wrong index or count.");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == OUT_APPENDED
        |-> m_axis_tdata[76:70] != 7'd0)
        else $error("Append reported an empty table.");

endmodule

bind cone_landmark_map_merge_core clmm_checker u_clmm_checker (.*);

`default_nettype wire
